[rtl/i2crm_pkg.sv]
// i2crm_pkg: types, codes and constants for the i2c register master
// used by every file under rtl
package i2crm_pkg;

  localparam int unsigned MaxBytes = 256;
  localparam int unsigned CntW = 9;
  localparam int unsigned QDepth = 2;

  typedef enum logic [1:0] {
    ACT_START = 2'd0,
    ACT_WBYTE = 2'd1,
    ACT_TICK  = 2'd2,
    ACT_NONE  = 2'd3
  } action_e;

  typedef enum logic [4:0] {
    PH_IDLE, PH_ST_REL, PH_ST_SDA, PH_ST_SCL, PH_TX_LOW, PH_TX_HIGH,
    PH_AK_LOW, PH_AK_HIGH, PH_GAP_A, PH_GAP_B, PH_WAIT, PH_RS_PREP,
    PH_RX_LOW, PH_RX_HIGH, PH_MA_LOW, PH_MA_HIGH, PH_SP_LOW, PH_SP_SCL,
    PH_SP_REL
  } phase_e;

  typedef enum logic [2:0] {
    STG_ADDR_W, STG_REG, STG_ADDR_R, STG_WDATA, STG_RDATA
  } stage_e;

  typedef enum logic [0:0] {
    CFG_DEV_ADDR = 1'd0,
    CFG_HALF_PER = 1'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0] action;
    logic       is_read;
    logic [7:0] register_index;
    logic [8:0] byte_count;
    logic [7:0] write_byte;
    logic       scl_sense;
    logic       sda_sense;
  } in_item_t;

  typedef struct packed {
    logic       scl_drive_low;
    logic       sda_drive_low;
    logic       byte_valid;
    logic [7:0] read_byte;
    logic       need_byte;
    logic       busy_res;
    logic       finished;
    logic       status;
  } out_item_t;

  // classified command passed from front to back
  typedef struct packed {
    action_e         action;
    logic            is_read;
    logic [7:0]      register_index;
    logic [CntW-1:0] count;
    logic [7:0]      write_byte;
    logic            scl_sense;
    logic            sda_sense;
  } cmd_t;

endpackage

[rtl/i2crm_front.sv]
// i2crm_front: accepts input beats, classifies them and saturates the count
// feeds a two-entry queue toward the sequencer; depends on i2crm_pkg
module i2crm_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid,
  output logic               in_ready,
  input  i2crm_pkg::in_item_t in_data,
  output logic               q_valid_o,
  input  logic               q_pop_i,
  output i2crm_pkg::cmd_t    q_cmd_o
);
  i2crm_pkg::cmd_t mem_q [i2crm_pkg::QDepth];
  logic rd_q, rd_d, wr_q, wr_d;
  logic [1:0] cnt_q, cnt_d;
  i2crm_pkg::cmd_t c;
  logic push;

  always_comb begin
    c.action = i2crm_pkg::action_e'(in_data.action);
    c.is_read = in_data.is_read;
    c.register_index = in_data.register_index;
    c.count = (in_data.byte_count > 9'(i2crm_pkg::MaxBytes)) ?
              9'(i2crm_pkg::MaxBytes) : in_data.byte_count;
    c.write_byte = in_data.write_byte;
    c.scl_sense = in_data.scl_sense;
    c.sda_sense = in_data.sda_sense;
  end

  assign in_ready = (cnt_q != 2'(i2crm_pkg::QDepth));
  assign push = in_valid && in_ready;
  assign q_valid_o = (cnt_q != 2'd0);
  assign q_cmd_o = mem_q[rd_q];
  assign rd_d = rd_q ^ (q_pop_i && q_valid_o);
  assign wr_d = wr_q ^ push;
  assign cnt_d = cnt_q + 2'(push) - 2'(q_pop_i && q_valid_o);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q <= 1'b0;
      wr_q <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      rd_q <= rd_d;
      wr_q <= wr_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= c;
  end
endmodule

[rtl/i2crm_seq.sv]
// i2crm_seq: bus sequencer; executes one queued command per cycle while its skid stage is
// empty, into an output register with a skid stage; depends on i2crm_pkg
module i2crm_seq (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 q_valid_i,
  output logic                 q_pop_o,
  input  i2crm_pkg::cmd_t      q_cmd_i,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2crm_pkg::out_item_t out_data
);
  i2crm_pkg::phase_e ph_q, ph_d;
  i2crm_pkg::stage_e stg_q, stg_d;
  logic [2:0]  bit_q, bit_d;
  logic [7:0]  sh_q, sh_d;
  logic [8:0]  left_q, left_d;
  logic [15:0] tk_q, tk_d;
  logic        dir_q, dir_d;
  logic [7:0]  reg_q, reg_d;
  logic [7:0]  pend_q, pend_d;
  logic        pv_q, pv_d, st_q, st_d;
  logic [6:0]  dev_q;
  logic [15:0] hp_q;
  logic        ov_q, sk_q;
  i2crm_pkg::out_item_t o_q, sk_d_q, res;
  logic        got, fin, done, stretch, fire;
  logic [7:0]  rb;
  logic [15:0] hp, tn;

  assign q_pop_o = q_valid_i && !sk_q;
  assign fire = q_pop_o;
  assign hp = (hp_q == 16'd0) ? 16'd1 : hp_q;
  assign stretch = (ph_q == i2crm_pkg::PH_ST_REL) || (ph_q == i2crm_pkg::PH_TX_HIGH) ||
                   (ph_q == i2crm_pkg::PH_AK_HIGH) || (ph_q == i2crm_pkg::PH_RX_HIGH) ||
                   (ph_q == i2crm_pkg::PH_MA_HIGH) || (ph_q == i2crm_pkg::PH_SP_SCL);
  assign tn = tk_q + 16'd1;

  always_comb begin
    ph_d = ph_q; stg_d = stg_q; bit_d = bit_q; sh_d = sh_q; left_d = left_q;
    tk_d = tk_q; dir_d = dir_q; reg_d = reg_q; pend_d = pend_q; pv_d = pv_q;
    st_d = st_q; got = 1'b0; fin = 1'b0; rb = 8'd0; done = 1'b0;
    case (q_cmd_i.action)
      i2crm_pkg::ACT_START: begin
        if (ph_q == i2crm_pkg::PH_IDLE) begin
          st_d = 1'b0;
          if (q_cmd_i.count == 9'd0) fin = 1'b1;
          else begin
            dir_d = q_cmd_i.is_read; reg_d = q_cmd_i.register_index;
            left_d = q_cmd_i.count; pv_d = 1'b0; stg_d = i2crm_pkg::STG_ADDR_W;
            bit_d = 3'd0; ph_d = i2crm_pkg::PH_ST_REL; tk_d = 16'd0;
          end
        end
      end
      i2crm_pkg::ACT_WBYTE: begin
        if (ph_q != i2crm_pkg::PH_IDLE && !dir_q && left_q != 9'd0 && !pv_q) begin
          pend_d = q_cmd_i.write_byte; pv_d = 1'b1;
        end
      end
      i2crm_pkg::ACT_TICK: begin
        if (ph_q == i2crm_pkg::PH_WAIT) begin
          if (pv_q) begin
            pv_d = 1'b0; left_d = left_q - 9'd1; sh_d = pend_q; bit_d = 3'd0;
            ph_d = i2crm_pkg::PH_TX_LOW; tk_d = 16'd0;
          end
        end else if (ph_q != i2crm_pkg::PH_IDLE && !(stretch && !q_cmd_i.scl_sense)) begin
          if (tn >= hp) begin tk_d = 16'd0; done = 1'b1; end
          else tk_d = tn;
        end
        if (done) begin
          tk_d = 16'd0;
          case (ph_q)
            i2crm_pkg::PH_ST_REL: ph_d = i2crm_pkg::PH_ST_SDA;
            i2crm_pkg::PH_ST_SDA: ph_d = i2crm_pkg::PH_ST_SCL;
            i2crm_pkg::PH_ST_SCL: begin
              sh_d = {dev_q, stg_q == i2crm_pkg::STG_ADDR_R};
              bit_d = 3'd0; ph_d = i2crm_pkg::PH_TX_LOW;
            end
            i2crm_pkg::PH_TX_LOW: ph_d = i2crm_pkg::PH_TX_HIGH;
            i2crm_pkg::PH_TX_HIGH: begin
              sh_d = {sh_q[6:0], 1'b0};
              if (bit_q == 3'd7) begin bit_d = 3'd0; ph_d = i2crm_pkg::PH_AK_LOW; end
              else begin bit_d = bit_q + 3'd1; ph_d = i2crm_pkg::PH_TX_LOW; end
            end
            i2crm_pkg::PH_AK_LOW: ph_d = i2crm_pkg::PH_AK_HIGH;
            i2crm_pkg::PH_AK_HIGH: begin
              if (q_cmd_i.sda_sense) begin st_d = 1'b1; ph_d = i2crm_pkg::PH_SP_LOW; end
              else ph_d = i2crm_pkg::PH_GAP_A;
            end
            i2crm_pkg::PH_GAP_A: ph_d = i2crm_pkg::PH_GAP_B;
            i2crm_pkg::PH_GAP_B: begin
              // next byte on the bus depends on which one just went out
              case (stg_q)
                i2crm_pkg::STG_ADDR_W: begin
                  stg_d = i2crm_pkg::STG_REG; sh_d = reg_q; bit_d = 3'd0;
                  ph_d = i2crm_pkg::PH_TX_LOW;
                end
                i2crm_pkg::STG_REG, i2crm_pkg::STG_WDATA: begin
                  if (stg_q == i2crm_pkg::STG_REG && dir_q) begin
                    stg_d = i2crm_pkg::STG_ADDR_R; ph_d = i2crm_pkg::PH_RS_PREP;
                  end else begin
                    stg_d = i2crm_pkg::STG_WDATA;
                    if (left_q == 9'd0) ph_d = i2crm_pkg::PH_SP_LOW;
                    else if (pv_q) begin
                      pv_d = 1'b0; left_d = left_q - 9'd1; sh_d = pend_q;
                      bit_d = 3'd0; ph_d = i2crm_pkg::PH_TX_LOW;
                    end else ph_d = i2crm_pkg::PH_WAIT;
                  end
                end
                default: begin
                  stg_d = i2crm_pkg::STG_RDATA;
                  if (stg_q != i2crm_pkg::STG_ADDR_R && left_q == 9'd0)
                    ph_d = i2crm_pkg::PH_SP_LOW;
                  else begin
                    left_d = left_q - 9'd1; bit_d = 3'd0; sh_d = 8'd0;
                    ph_d = i2crm_pkg::PH_RX_LOW;
                  end
                end
              endcase
            end
            i2crm_pkg::PH_RS_PREP: ph_d = i2crm_pkg::PH_ST_REL;
            i2crm_pkg::PH_RX_LOW: ph_d = i2crm_pkg::PH_RX_HIGH;
            i2crm_pkg::PH_RX_HIGH: begin
              sh_d = {sh_q[6:0], q_cmd_i.sda_sense};
              if (bit_q == 3'd7) begin
                bit_d = 3'd0; got = 1'b1; rb = sh_d; ph_d = i2crm_pkg::PH_MA_LOW;
              end else begin bit_d = bit_q + 3'd1; ph_d = i2crm_pkg::PH_RX_LOW; end
            end
            i2crm_pkg::PH_MA_LOW: ph_d = i2crm_pkg::PH_MA_HIGH;
            i2crm_pkg::PH_MA_HIGH: ph_d = i2crm_pkg::PH_GAP_A;
            i2crm_pkg::PH_SP_LOW: ph_d = i2crm_pkg::PH_SP_SCL;
            i2crm_pkg::PH_SP_SCL: ph_d = i2crm_pkg::PH_SP_REL;
            i2crm_pkg::PH_SP_REL: begin ph_d = i2crm_pkg::PH_IDLE; fin = 1'b1; end
            default: ph_d = i2crm_pkg::PH_IDLE;
          endcase
        end
      end
      default: ;
    endcase

    res = '0;
    case (ph_d)
      i2crm_pkg::PH_ST_SDA, i2crm_pkg::PH_SP_SCL: res.sda_drive_low = 1'b1;
      i2crm_pkg::PH_ST_SCL, i2crm_pkg::PH_GAP_A, i2crm_pkg::PH_GAP_B,
      i2crm_pkg::PH_WAIT, i2crm_pkg::PH_SP_LOW: begin
        res.scl_drive_low = 1'b1; res.sda_drive_low = 1'b1;
      end
      i2crm_pkg::PH_TX_LOW: begin
        res.scl_drive_low = 1'b1; res.sda_drive_low = !sh_d[7];
      end
      i2crm_pkg::PH_TX_HIGH: res.sda_drive_low = !sh_d[7];
      i2crm_pkg::PH_AK_LOW, i2crm_pkg::PH_RS_PREP, i2crm_pkg::PH_RX_LOW:
        res.scl_drive_low = 1'b1;
      i2crm_pkg::PH_MA_LOW: begin
        res.scl_drive_low = 1'b1; res.sda_drive_low = (left_d != 9'd0);
      end
      i2crm_pkg::PH_MA_HIGH: res.sda_drive_low = (left_d != 9'd0);
      default: ;
    endcase
    res.byte_valid = got;
    res.read_byte = rb;
    res.need_byte = (ph_d != i2crm_pkg::PH_IDLE) && !dir_d && (left_d != 9'd0) && !pv_d;
    res.busy_res = (ph_d != i2crm_pkg::PH_IDLE);
    res.finished = fin;
    res.status = st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= i2crm_pkg::PH_IDLE; stg_q <= i2crm_pkg::STG_ADDR_W; bit_q <= 3'd0;
      sh_q <= 8'd0; left_q <= 9'd0; tk_q <= 16'd0; dir_q <= 1'b0; reg_q <= 8'd0;
      pv_q <= 1'b0; st_q <= 1'b0; dev_q <= 7'd0; hp_q <= 16'd100;
      ov_q <= 1'b0; sk_q <= 1'b0;
    end else begin
      if (fire) begin
        ph_q <= ph_d; stg_q <= stg_d; bit_q <= bit_d; sh_q <= sh_d; left_q <= left_d;
        tk_q <= tk_d; dir_q <= dir_d; reg_q <= reg_d; pv_q <= pv_d; st_q <= st_d;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          i2crm_pkg::CFG_DEV_ADDR: dev_q <= cfg_data_i[6:0];
          i2crm_pkg::CFG_HALF_PER: hp_q <= cfg_data_i;
          default: ;
        endcase
      end
      // output register plus skid beat
      if (!ov_q || out_ready) begin
        ov_q <= fire || sk_q;
        sk_q <= 1'b0;
      end else if (fire) sk_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) pend_q <= pend_d;
    if (!ov_q || out_ready) o_q <= sk_q ? sk_d_q : res;
    else if (fire) sk_d_q <= res;
  end

  assign out_valid = ov_q;
  assign out_data = o_q;
endmodule

[rtl/i2c_register_master.sv]
// i2c_register_master: top level, front classifier, queue and bus sequencer
// depends on i2crm_pkg, i2crm_front, i2crm_seq
//
// channel  | handshake            | payload
// in       | in_valid/in_ready    | in_data  (i2crm_pkg::in_item_t)
// out      | out_valid/out_ready  | out_data (i2crm_pkg::out_item_t)
// cfg      | cfg_we_i             | cfg_idx_i, cfg_data_i
//
// one beat a cycle while neither side stalls; a beat waits in the queue, its result in the output register
// the sequencer state update is one step per beat
// a two-entry queue and an output skid stage let each side stall alone
// reset is asynchronous and active low; no clearing pass
module i2c_register_master (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [0:0]           cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  i2crm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output i2crm_pkg::out_item_t out_data
);
  logic q_valid, q_pop;
  i2crm_pkg::cmd_t q_cmd;

  i2crm_front u_front (
    .clk_i, .rst_ni, .in_valid, .in_ready, .in_data,
    .q_valid_o(q_valid), .q_pop_i(q_pop), .q_cmd_o(q_cmd)
  );

  i2crm_seq u_seq (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .q_valid_i(q_valid), .q_pop_o(q_pop), .q_cmd_i(q_cmd),
    .out_valid, .out_ready, .out_data
  );
endmodule

[rtl/i2crm_checker.sv]
// i2crm_checker: port-level assertions for i2c_register_master
// depends on i2crm_pkg; bound to the top level below
module i2crm_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 out_valid,
  input logic                 out_ready,
  input i2crm_pkg::out_item_t out_data
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result beat dropped while stalled");
  a_rb: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_data.byte_valid |-> out_data.read_byte == 8'd0)
    else $error("read byte without byte valid");
  a_fin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.finished |-> !out_data.busy_res)
    else $error("finished while busy");
  a_need: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && out_data.need_byte |-> out_data.busy_res)
    else $error("need byte while idle");
endmodule

bind i2c_register_master i2crm_checker u_chk (.*);

[bench/i2c_register_master_test.sv]
// i2c_register_master_test: self-checking bench for the i2c register master
// depends on i2crm_pkg and i2c_register_master; predicts every result beat in order
`timescale 1ns / 100ps

module i2c_register_master_test;
  import i2crm_pkg::*;

  localparam int unsigned CycleLimit = 600000;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [0:0]  cfg_idx_i = CFG_DEV_ADDR;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_item_t   out_data;

  i2c_register_master dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .in_valid, .in_ready, .in_data, .out_valid, .out_ready, .out_data
  );

  always #6 clk_i = ~clk_i;

  // bus sequencer mirror
  logic [6:0]  dev_addr;
  logic [15:0] half_per;
  phase_e      ph;
  stage_e      stg;
  logic [2:0]  bit_cnt;
  logic [7:0]  shreg;
  logic [8:0]  bytes_left;
  logic [15:0] tick_cnt;
  logic        dir_rd;
  logic [7:0]  reg_hold;
  logic [7:0]  held_byte;
  logic        held_valid;
  logic        nack_status;

  out_item_t   expected_q[$];
  int unsigned mismatches = 0;
  int unsigned beats_sent = 0;
  int unsigned beats_checked = 0;
  int unsigned reads_seen = 0;
  int unsigned nacks_seen = 0;
  int unsigned xfers_done = 0;
  int unsigned cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;

  function automatic bit stretch_phase(phase_e p);
    return p inside {PH_ST_REL, PH_TX_HIGH, PH_AK_HIGH, PH_RX_HIGH, PH_MA_HIGH, PH_SP_SCL};
  endfunction

  function automatic void go(phase_e p);
    ph = p;
    tick_cnt = '0;
  endfunction

  function automatic bit step_end(logic scl);
    int unsigned lim, n;
    lim = (half_per == 0) ? 1 : half_per;
    if (stretch_phase(ph) && !scl) return 1'b0;
    n = tick_cnt + 1;
    if (n >= lim) begin
      tick_cnt = '0;
      return 1'b1;
    end
    tick_cnt = n[15:0];
    return 1'b0;
  endfunction

  function automatic void load_tx(logic [7:0] b);
    shreg = b;
    bit_cnt = '0;
    go(PH_TX_LOW);
  endfunction

  function automatic void next_wdata();
    if (bytes_left == 0) go(PH_SP_LOW);
    else if (held_valid) begin
      held_valid = 1'b0;
      bytes_left--;
      load_tx(held_byte);
    end else go(PH_WAIT);
  endfunction

  function automatic void rx_begin();
    bytes_left--;
    bit_cnt = '0;
    shreg = '0;
    go(PH_RX_LOW);
  endfunction

  function automatic void after_gap();
    case (stg)
      STG_ADDR_W: begin
        stg = STG_REG;
        load_tx(reg_hold);
      end
      STG_REG: begin
        if (dir_rd) begin
          stg = STG_ADDR_R;
          go(PH_RS_PREP);
        end else begin
          stg = STG_WDATA;
          next_wdata();
        end
      end
      STG_ADDR_R: begin
        stg = STG_RDATA;
        rx_begin();
      end
      STG_WDATA: next_wdata();
      default: begin
        if (bytes_left == 0) go(PH_SP_LOW);
        else rx_begin();
      end
    endcase
  endfunction

  function automatic void bus_tick(logic scl, logic sda, ref out_item_t r);
    if (ph == PH_IDLE) return;
    if (ph == PH_WAIT) begin
      if (held_valid) begin
        held_valid = 1'b0;
        bytes_left--;
        load_tx(held_byte);
      end
      return;
    end
    if (!step_end(scl)) return;
    case (ph)
      PH_ST_REL: go(PH_ST_SDA);
      PH_ST_SDA: go(PH_ST_SCL);
      PH_ST_SCL: load_tx({dev_addr, stg == STG_ADDR_R});
      PH_TX_LOW: go(PH_TX_HIGH);
      PH_TX_HIGH: begin
        shreg = shreg << 1;
        if (bit_cnt == 3'd7) begin
          bit_cnt = '0;
          go(PH_AK_LOW);
        end else begin
          bit_cnt++;
          go(PH_TX_LOW);
        end
      end
      PH_AK_LOW: go(PH_AK_HIGH);
      PH_AK_HIGH: begin
        if (sda) begin
          nack_status = 1'b1;
          go(PH_SP_LOW);
        end else go(PH_GAP_A);
      end
      PH_GAP_A: go(PH_GAP_B);
      PH_GAP_B: after_gap();
      PH_RS_PREP: go(PH_ST_REL);
      PH_RX_LOW: go(PH_RX_HIGH);
      PH_RX_HIGH: begin
        shreg = {shreg[6:0], sda};
        if (bit_cnt == 3'd7) begin
          bit_cnt = '0;
          r.byte_valid = 1'b1;
          r.read_byte = shreg;
          go(PH_MA_LOW);
        end else begin
          bit_cnt++;
          go(PH_RX_LOW);
        end
      end
      PH_MA_LOW: go(PH_MA_HIGH);
      PH_MA_HIGH: go(PH_GAP_A);
      PH_SP_LOW: go(PH_SP_SCL);
      PH_SP_SCL: go(PH_SP_REL);
      PH_SP_REL: begin
        go(PH_IDLE);
        r.finished = 1'b1;
      end
      default: go(PH_IDLE);
    endcase
  endfunction

  function automatic out_item_t predict_bus(in_item_t it);
    out_item_t r;
    logic [8:0] cnt;
    r = '0;
    case (action_e'(it.action))
      ACT_START: begin
        if (ph == PH_IDLE) begin
          cnt = (it.byte_count > MaxBytes) ? 9'(MaxBytes) : it.byte_count;
          nack_status = 1'b0;
          if (cnt == 0) r.finished = 1'b1;
          else begin
            dir_rd = it.is_read;
            reg_hold = it.register_index;
            bytes_left = cnt;
            held_valid = 1'b0;
            stg = STG_ADDR_W;
            bit_cnt = '0;
            go(PH_ST_REL);
          end
        end
      end
      ACT_WBYTE: begin
        if (ph != PH_IDLE && !dir_rd && bytes_left != 0 && !held_valid) begin
          held_byte = it.write_byte;
          held_valid = 1'b1;
        end
      end
      ACT_TICK: bus_tick(it.scl_sense, it.sda_sense, r);
      default: ;
    endcase
    case (ph)
      PH_ST_SDA, PH_SP_SCL: r.sda_drive_low = 1'b1;
      PH_ST_SCL, PH_GAP_A, PH_GAP_B, PH_WAIT, PH_SP_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = 1'b1;
      end
      PH_TX_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = ~shreg[7];
      end
      PH_TX_HIGH: r.sda_drive_low = ~shreg[7];
      PH_AK_LOW, PH_RS_PREP, PH_RX_LOW: r.scl_drive_low = 1'b1;
      PH_MA_LOW: begin
        r.scl_drive_low = 1'b1;
        r.sda_drive_low = (bytes_left != 0);
      end
      PH_MA_HIGH: r.sda_drive_low = (bytes_left != 0);
      default: ;
    endcase
    r.need_byte = (ph != PH_IDLE) && !dir_rd && (bytes_left != 0) && !held_valid;
    r.busy_res = (ph != PH_IDLE);
    r.status = nack_status;
    return r;
  endfunction

  function automatic in_item_t rand_item(action_e a);
    in_item_t it;
    it = in_item_t'({$urandom, $urandom});
    it.action = a;
    return it;
  endfunction

  // one input beat; in_valid stays high on return so a back-to-back beat needs no toggle
  task automatic send_beat(in_item_t it);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    expected_q.push_back(predict_bus(it));
    beats_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [15:0] val);
    drain();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_DEV_ADDR) dev_addr = val[6:0];
    else half_per = val;
  endtask

  // one transfer driven to completion by ticks; nack_pct applies to each ack bit
  task automatic run_xfer(bit rd, logic [7:0] regi, logic [8:0] cnt, int unsigned nack_pct,
                          bit extreme_data);
    in_item_t it;
    int unsigned r;
    it = rand_item(ACT_START);
    it.is_read = rd;
    it.register_index = regi;
    it.byte_count = cnt;
    send_beat(it);
    while (ph != PH_IDLE) begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        it = rand_item(action_e'($urandom_range(0, 1) ? ACT_NONE : ACT_START));
      end else if (r < 7) begin
        it = rand_item(ACT_WBYTE);
      end else if (!dir_rd && bytes_left != 0 && !held_valid && r < 60) begin
        it = rand_item(ACT_WBYTE);
        if (extreme_data) it.write_byte = $urandom_range(0, 1) ? 8'hFF : 8'h00;
      end else begin
        it = rand_item(ACT_TICK);
        it.scl_sense = !(stretch_phase(ph) && $urandom_range(0, 4) == 0);
        if (ph == PH_AK_HIGH) it.sda_sense = ($urandom_range(0, 99) < nack_pct);
      end
      send_beat(it);
    end
    if (nack_status) nacks_seen++;
    xfers_done++;
  endtask

  task automatic test_idle_corners();
    in_item_t it;
    send_beat(rand_item(ACT_NONE));
    it = rand_item(ACT_WBYTE);
    it.write_byte = 8'hFF;
    send_beat(it);
    send_beat(rand_item(ACT_TICK));
    it = rand_item(ACT_START);
    it.is_read = 1'b1;
    it.register_index = 8'hFF;
    it.byte_count = 9'd0;
    send_beat(it);
    it.is_read = 1'b0;
    it.register_index = 8'h00;
    send_beat(it);
  endtask

  task automatic test_write_path();
    write_cfg(CFG_DEV_ADDR, 16'h007F);
    write_cfg(CFG_HALF_PER, 16'h0000);
    run_xfer(1'b0, 8'hFF, 9'd2, 0, 1'b1);
  endtask

  task automatic test_read_path();
    write_cfg(CFG_DEV_ADDR, 16'h0000);
    write_cfg(CFG_HALF_PER, 16'h0001);
    run_xfer(1'b1, 8'hA5, 9'd1, 0, 1'b0);
  endtask

  task automatic test_nack_and_saturation();
    write_cfg(CFG_HALF_PER, 16'h0001);
    run_xfer(1'b0, 8'h3C, 9'd511, 40, 1'b0);
    run_xfer(1'b1, 8'hC3, 9'd256, 100, 1'b0);
  endtask

  task automatic test_slow_clock_setting();
    in_item_t it;
    write_cfg(CFG_HALF_PER, 16'hFFFF);
    it = rand_item(ACT_START);
    it.byte_count = 9'd0;
    send_beat(it);
    send_beat(rand_item(ACT_TICK));
    write_cfg(CFG_HALF_PER, 16'h0001);
  endtask

  task automatic test_random_traffic();
    int unsigned start_beats, r;
    logic [8:0] cnt;
    bit rd;
    start_beats = beats_sent;
    while (beats_sent - start_beats < 60) begin
      if ($urandom_range(0, 5) == 0) write_cfg(CFG_DEV_ADDR, 16'($urandom_range(0, 127)));
      if ($urandom_range(0, 5) == 0) write_cfg(CFG_HALF_PER, 16'($urandom_range(0, 2)));
      rd = 1'($urandom_range(0, 1));
      r = $urandom_range(0, 99);
      // large counts only on writes, where a nack ends them early
      cnt = (r < 6) ? 9'd0 : (r < 10 && !rd) ? 9'($urandom_range(257, 511)) :
            9'($urandom_range(1, 3));
      run_xfer(rd, 8'($urandom), cnt, (cnt > 3) ? 35 : 8, 1'b0);
    end
  endtask

  task automatic test_output_backpressure();
    hold_req = 1'b1;
    run_xfer(1'b0, 8'h5A, 9'd1, 0, 1'b0);
  endtask

  // last stretch runs with no idling on either side
  task automatic test_streaming_tail();
    quiet = 1'b1;
    run_xfer(1'b1, 8'h42, 9'd1, 0, 1'b0);
  endtask

  initial begin
    dev_addr = '0;
    half_per = 16'd100;
    ph = PH_IDLE;
    stg = STG_ADDR_W;
    bit_cnt = '0;
    shreg = '0;
    bytes_left = '0;
    tick_cnt = '0;
    dir_rd = 1'b0;
    reg_hold = '0;
    held_byte = '0;
    held_valid = 1'b0;
    nack_status = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_idle_corners();
    test_write_path();
    test_read_path();
    test_nack_and_saturation();
    test_slow_clock_setting();
    test_random_traffic();
    test_output_backpressure();
    test_streaming_tail();
    drain();
    repeat (20) @(posedge clk_i);
    $display("ran %0d transfers in %0d beats, %0d read bytes and %0d nacked transfers",
             xfers_done, beats_checked, reads_seen, nacks_seen);
    $display("covered zero and saturated counts, clock stretch, missing write data, stalls");
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // receiver side: random stall bursts plus one long hold-off on request
  initial begin
    @(posedge clk_i);
    while (!rst_ni) @(posedge clk_i);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        @(posedge clk_i);
      end
    end
  end

  always @(posedge clk_i) begin
    out_item_t exp_r;
    if (rst_ni && out_valid && out_ready) begin
      beats_checked++;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %h", out_data);
      end else begin
        exp_r = expected_q.pop_front();
        if (exp_r.byte_valid) reads_seen++;
        if (out_data !== exp_r) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"beat %0d mismatch: scl %b/%b sda %b/%b bv %b/%b rb %h/%h need %b/%b",
                      " busy %b/%b fin %b/%b st %b/%b (exp/act)"}, beats_checked,
                     exp_r.scl_drive_low, out_data.scl_drive_low,
                     exp_r.sda_drive_low, out_data.sda_drive_low,
                     exp_r.byte_valid, out_data.byte_valid, exp_r.read_byte, out_data.read_byte,
                     exp_r.need_byte, out_data.need_byte, exp_r.busy_res, out_data.busy_res,
                     exp_r.finished, out_data.finished, exp_r.status, out_data.status);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles", cycles);
      $display("Verification failed");
      $finish;
    end
  end

endmodule
